@@ hw/rtl/sdbt_pkg.sv @@
// Package: shared widths, constants and controller/datapath command types.
package sdbt_pkg;

  localparam int unsigned NumBucketsDefault = 16;
  localparam int unsigned TimeWidthDefault  = 32;
  localparam int unsigned CountWidth        = 32;
  localparam int unsigned OpWidth           = 2;
  localparam int unsigned OldTimeWidth      = 32;
  localparam logic [CountWidth-1:0] LimitReset = 32'd1024;
  localparam logic [CountWidth-1:0] CountMax   = '1;

  typedef enum logic [OpWidth-1:0] {
    OP_INSERT   = 2'd0,
    OP_REACCESS = 2'd1,
    OP_DECR     = 2'd2,
    OP_NONE     = 2'd3
  } opcode_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;       // latch the incoming item
    logic inc;        // add one to the newest bucket
    logic scan_clr;   // restart the bucket scan
    logic age_step;   // examine one bucket for the least pair
    logic age_apply;  // merge, shift and open a fresh newest bucket
    logic lk_step;    // accumulate one bucket of the lookup
    logic lk_fin;     // take one from the hit bucket, form the distance
  } sdbt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OpWidth-1:0] op;
    logic full;       // newest bucket has reached the limit
    logic last;       // scan index is on the oldest bucket
    logic hit;        // current bucket matches the old timestamp
  } sdbt_stat_t;

endpackage

@@ hw/rtl/sdbt_item_if.sv @@
// Interfaces: input item channel and result item channel.
interface sdbt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [sdbt_pkg::OpWidth-1:0]         opcode;
  logic [sdbt_pkg::OldTimeWidth-1:0]    old_time;
  modport source (output valid, opcode, old_time, input ready);
  modport sink   (input valid, opcode, old_time, output ready);
endinterface

interface sdbt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [sdbt_pkg::CountWidth-1:0]      stack_distance;
  logic                                 distance_valid;
  modport source (output valid, stack_distance, distance_valid, input ready);
  modport sink   (input valid, stack_distance, distance_valid, output ready);
endinterface

@@ hw/rtl/sdbt_datapath.sv @@
// Datapath: bucket registers, timestamp counter, size limit and scan logic.
module sdbt_datapath #(
  parameter int unsigned BUCKETS    = sdbt_pkg::NumBucketsDefault,
  parameter int unsigned TIME_WIDTH = sdbt_pkg::TimeWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sdbt_pkg::CountWidth-1:0]     cfg_wdata_i,
  input  logic [sdbt_pkg::OpWidth-1:0]        opcode_i,
  input  logic [sdbt_pkg::OldTimeWidth-1:0]   old_time_i,
  input  sdbt_pkg::sdbt_cmd_t                 cmd_i,
  output sdbt_pkg::sdbt_stat_t                stat_o,
  output logic [sdbt_pkg::CountWidth-1:0]     dist_o
);
  import sdbt_pkg::*;

  localparam int unsigned IdxW = $clog2(BUCKETS);
  localparam int unsigned CmpW = (TIME_WIDTH > OldTimeWidth) ? TIME_WIDTH : OldTimeWidth;
  localparam int unsigned SumW = CountWidth + IdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BUCKETS - 1);

  logic [CountWidth-1:0] cnt_q   [BUCKETS];
  logic [TIME_WIDTH-1:0] start_q [BUCKETS];
  logic [TIME_WIDTH-1:0] time_q;
  logic [CountWidth-1:0] limit_q;
  logic [OpWidth-1:0]    op_q;
  logic [OldTimeWidth-1:0] old_q;
  logic [IdxW-1:0]       idx_q;
  logic [CountWidth-1:0] prev_q;
  logic [IdxW-1:0]       best_q;
  logic [CountWidth:0]   best_sum_q;
  logic                  first_q;
  logic [SumW-1:0]       sum_q;
  logic [CountWidth-1:0] dist_q;

  logic [CountWidth-1:0] cur_cnt;
  logic [TIME_WIDTH-1:0] cur_start;
  logic [CountWidth:0]   pair_sum;
  logic [CountWidth-1:0] merged;
  logic [SumW-1:0]       sum_d;
  logic [SumW-1:0]       sum_m1;
  logic                  hit;
  logic [IdxW-1:0]       merge_idx;

  // Read one bucket at the scan index
  assign cur_cnt   = cnt_q[idx_q];
  assign cur_start = start_q[idx_q];
  assign pair_sum  = {1'b0, prev_q} + {1'b0, cur_cnt};
  assign merged    = best_sum_q[CountWidth] ? CountMax : best_sum_q[CountWidth-1:0];
  assign merge_idx = best_q + IdxW'(1);
  assign hit       = (cur_start == '0) ||
                     (CmpW'(cur_start) < CmpW'(old_q));
  assign sum_d     = sum_q + SumW'(cur_cnt);
  assign sum_m1    = (sum_d == '0) ? '0 : sum_d - SumW'(1);

  assign stat_o.op   = op_q;
  assign stat_o.full = (cnt_q[0] >= limit_q);
  assign stat_o.last = (idx_q == LastIdx);
  assign stat_o.hit  = hit;
  assign dist_o      = dist_q;

  // Control registers: limit, timestamp, scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LimitReset;
      time_q     <= '0;
      idx_q      <= '0;
      first_q    <= 1'b1;
      best_q     <= '0;
      best_sum_q <= '0;
      prev_q     <= '0;
      sum_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        first_q <= 1'b1;
        sum_q   <= '0;
      end
      // Track the least adjacent pair, ties to the older pair
      if (cmd_i.age_step) begin
        prev_q <= cur_cnt;
        if (idx_q != '0 && (first_q || pair_sum <= best_sum_q)) begin
          best_q     <= idx_q - IdxW'(1);
          best_sum_q <= pair_sum;
          first_q    <= 1'b0;
        end
        if (idx_q != LastIdx) idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.age_apply) begin
        time_q <= time_q + TIME_WIDTH'(1);
        if (merged > limit_q) begin
          limit_q <= limit_q[CountWidth-1] ? CountMax : {limit_q[CountWidth-2:0], 1'b0};
        end
      end
      // Accumulate counts toward the distance
      if (cmd_i.lk_step) begin
        sum_q <= sum_d;
        if (!hit && idx_q != LastIdx) idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Item payload and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= opcode_i;
      old_q <= old_time_i;
    end
    if (cmd_i.take) begin
      dist_q <= '0;
    end else if (cmd_i.lk_fin) begin
      dist_q <= (sum_m1 > SumW'(CountMax)) ? CountMax : sum_m1[CountWidth-1:0];
    end
  end

  // Bucket registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUCKETS; i++) begin
        cnt_q[i]   <= '0;
        start_q[i] <= '0;
      end
    end else begin
      if (cmd_i.inc && cnt_q[0] != CountMax) begin
        cnt_q[0] <= cnt_q[0] + CountWidth'(1);
      end
      if (cmd_i.age_apply) begin
        for (int i = 1; i < BUCKETS; i++) begin
          if (IdxW'(i) <= best_q) begin
            cnt_q[i]   <= cnt_q[i-1];
            start_q[i] <= start_q[i-1];
          end
        end
        cnt_q[merge_idx] <= merged;
        cnt_q[0]         <= '0;
        start_q[0]       <= time_q + TIME_WIDTH'(1);
      end
      if (cmd_i.lk_fin && cur_cnt != '0) begin
        cnt_q[idx_q] <= cur_cnt - CountWidth'(1);
      end
    end
  end

endmodule

@@ hw/rtl/sdbt_ctrl.sv @@
// Controller: sequences increment, aging scan and distance lookup per item.
module sdbt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [sdbt_pkg::OpWidth-1:0] opcode_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_flag_o,
  output logic                  out_load_o,
  input  sdbt_pkg::sdbt_stat_t  stat_i,
  output sdbt_pkg::sdbt_cmd_t   cmd_o
);
  import sdbt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StInc   = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StAge   = 3'd3;
  localparam logic [2:0] StApply = 3'd4;
  localparam logic [2:0] StLook  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       oflag_q;
  logic       load;
  logic       lookup;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_flag_o  = oflag_q;
  assign out_load_o  = load;
  assign lookup      = stat_i.op inside {OP_REACCESS, OP_DECR};
  assign load        = (state_q == StOut) && (!ovalid_q || out_ready_i);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          if (opcode_i inside {OP_INSERT, OP_REACCESS}) state_d = StInc;
          else if (opcode_i == OP_DECR) state_d = StLook;
          else state_d = StOut;
        end
      end
      StInc: begin
        cmd_o.inc = 1'b1;
        state_d   = StCheck;
      end
      StCheck: begin
        cmd_o.scan_clr = 1'b1;
        if (stat_i.full) state_d = StAge;
        else if (lookup) state_d = StLook;
        else state_d = StOut;
      end
      StAge: begin
        cmd_o.age_step = 1'b1;
        if (stat_i.last) state_d = StApply;
      end
      StApply: begin
        cmd_o.age_apply = 1'b1;
        cmd_o.scan_clr  = 1'b1;
        state_d = lookup ? StLook : StOut;
      end
      StLook: begin
        cmd_o.lk_step = 1'b1;
        if (stat_i.hit || stat_i.last) begin
          cmd_o.lk_fin = 1'b1;
          state_d      = StOut;
        end
      end
      StOut: begin
        if (load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    ovalid_d = ovalid_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (load) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      oflag_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (load) oflag_q <= lookup;
    end
  end

endmodule

@@ hw/rtl/stack_distance_bucket_tracker_unit.sv @@
// Top level: timestamp bucket tracker estimating stack distances.
// Usage:
//   in_i carries items (opcode, old_time) with valid/ready; out_o
//   returns one result item (stack_distance, distance_valid) per input item.
//   cfg_we_i/cfg_wdata_i load the bucket size limit; write only when idle.
// Sequencing:
//   One item at a time. Insert and reaccess add one to the newest bucket;
//   when it fills, the pair scan runs and merges the least pair. Lookup
//   for reaccess and decrement scans one bucket per cycle until the
//   timestamp matches or the oldest bucket is reached.
// Output:
//   The result sits in an output register; a new item is accepted while a
//   result waits. If the receiver stalls, the next result waits in the
//   datapath until the output register frees.
// Reset:
//   rst_ni clears all buckets and the timestamp, and loads limit 1024.
module stack_distance_bucket_tracker_unit #(
  parameter int unsigned BUCKETS    = sdbt_pkg::NumBucketsDefault,
  parameter int unsigned TIME_WIDTH = sdbt_pkg::TimeWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sdbt_pkg::CountWidth-1:0]  cfg_wdata_i,
  sdbt_in_if.sink                          in_i,
  sdbt_out_if.source                       out_o
);
  import sdbt_pkg::*;

  sdbt_cmd_t             cmd;
  sdbt_stat_t            stat;
  logic [CountWidth-1:0] dp_distance;
  logic [CountWidth-1:0] dist_q;
  logic                  load;
  logic                  flag;

  sdbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .opcode_i    (in_i.opcode),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_flag_o  (flag),
    .out_load_o  (load),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sdbt_datapath #(
    .BUCKETS    (BUCKETS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .opcode_i    (in_i.opcode),
    .old_time_i  (in_i.old_time),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .dist_o      (dp_distance)
  );

  // Output register for the distance
  always_ff @(posedge clk_i) begin
    if (load) dist_q <= dp_distance;
  end

  assign out_o.stack_distance = dist_q;
  assign out_o.distance_valid = flag;

endmodule

@@ dv/stack_distance_bucket_tracker_unit_tb.sv @@
// Testbench for the stack distance bucket tracker: directed table, random items, scoreboard.
module stack_distance_bucket_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdbt_pkg::*;

  localparam int unsigned NB = NumBucketsDefault;
  localparam int unsigned NumRandom = 1000;
  localparam longint unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [31:0] distance;
    logic        dvalid;
  } result_t;

  typedef struct {
    opcode_e     op;
    logic [31:0] old_time;
    logic        check_dist;
    logic [31:0] distance;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  int          errors;
  longint unsigned cycles;

  sdbt_in_if  in_ch ();
  sdbt_out_if out_ch ();

  stack_distance_bucket_tracker_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  // Predictor state
  logic [31:0] cnt_q [NB];
  logic [31:0] start_q [NB];
  logic [31:0] tstamp_q;
  logic [31:0] limit_q;
  result_t     pending_q [$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stop the run at a generous cycle bound
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** stack_distance_bucket_tracker_unit: FAILED **");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, exp);
  endtask

  function automatic void model_reset(input logic [31:0] lim);
    for (int i = 0; i < NB; i++) begin
      cnt_q[i] = '0;
      start_q[i] = '0;
    end
    tstamp_q = '0;
    limit_q = lim;
  endfunction

  // Merge the least adjacent pair (oldest on ties) and open a new bucket
  function automatic void merge_oldest_least();
    int best;
    logic [63:0] best_sum, s, d;
    best = 0;
    best_sum = 64'h7FFF_FFFF_FFFF_FFFF;
    for (int i = 0; i + 1 < NB; i++) begin
      s = 64'(cnt_q[i]) + 64'(cnt_q[i+1]);
      if (s <= best_sum) begin
        best = i;
        best_sum = s;
      end
    end
    if (best_sum > 64'hFFFF_FFFF) best_sum = 64'hFFFF_FFFF;
    cnt_q[best+1] = best_sum[31:0];
    if (best_sum > 64'(limit_q)) begin
      d = 64'(limit_q) * 2;
      limit_q = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
    end
    for (int i = best; i > 0; i--) begin
      cnt_q[i] = cnt_q[i-1];
      start_q[i] = start_q[i-1];
    end
    tstamp_q = tstamp_q + 1;
    cnt_q[0] = '0;
    start_q[0] = tstamp_q;
  endfunction

  function automatic void bump_newest();
    if (cnt_q[0] != 32'hFFFF_FFFF) cnt_q[0] = cnt_q[0] + 1;
    if (cnt_q[0] >= limit_q) merge_oldest_least();
  endfunction

  function automatic logic [31:0] distance_of(input logic [31:0] old_t);
    logic [63:0] sum;
    int hit;
    sum = '0;
    hit = NB - 1;
    for (int i = 0; i < NB; i++) begin
      sum += 64'(cnt_q[i]);
      if (start_q[i] == 0 || start_q[i] < old_t) begin
        hit = i;
        break;
      end
    end
    if (cnt_q[hit] > 0) cnt_q[hit] = cnt_q[hit] - 1;
    if (sum > 0) sum -= 1;
    return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic result_t predict_distance(input opcode_e op, input logic [31:0] old_t);
    result_t r;
    r = '0;
    case (op)
      OP_INSERT: bump_newest();
      OP_REACCESS: begin
        bump_newest();
        r.distance = distance_of(old_t);
        r.dvalid = 1'b1;
      end
      OP_DECR: begin
        r.distance = distance_of(old_t);
        r.dvalid = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random stalls, compare each result with the oldest expectation
  initial begin
    int stall;
    result_t e;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      // Sample mid-cycle; the next rising edge takes the item
      @(negedge clk_i);
      while (!out_ch.valid) @(negedge clk_i);
      if (pending_q.size() == 0) begin
        report("unexpected result", out_ch.stack_distance, 32'h0);
      end else begin
        e = pending_q.pop_front();
        if (out_ch.stack_distance !== e.distance)
          report("stack_distance", out_ch.stack_distance, e.distance);
        if (out_ch.distance_valid !== e.dvalid)
          report("distance_valid", 32'(out_ch.distance_valid), 32'(e.dvalid));
      end
      @(posedge clk_i);
    end
  end

  // Hold the item until it is taken, then queue its expected result
  task automatic send_item(input opcode_e op, input logic [31:0] old_t, input logic chk,
                           input logic [31:0] exp_dist);
    int gap;
    result_t r;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.old_time <= old_t;
    // Check ready mid-cycle; the next rising edge accepts the item
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    r = predict_distance(op, old_t);
    if (chk && r.distance !== exp_dist) report("table distance", r.distance, exp_dist);
    pending_q.push_back(r);
  endtask

  task automatic drain(input int extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] lim);
    drain(2 * NB + 10);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_q = lim;
  endtask

  // Pick an old timestamp near the live bucket starts half of the time
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return '0;
      default: return tstamp_q - $urandom_range(0, NB + 2) + $urandom_range(0, 2);
    endcase
  endfunction

  function automatic opcode_e pick_op();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return OP_NONE;
    if (r < 9) return OP_INSERT;
    if (r < 15) return OP_REACCESS;
    return OP_DECR;
  endfunction

  // Main sequence
  initial begin
    row_t tbl [$];
    logic [31:0] lims [5];
    errors = 0;
    cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_INSERT;
    in_ch.old_time = '0;
    model_reset(LimitReset);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty tracker, extremes of old_time, every opcode
    tbl.push_back('{OP_DECR, 32'h0, 1'b1, 32'd0});
    tbl.push_back('{OP_DECR, 32'hFFFF_FFFF, 1'b1, 32'd0});
    tbl.push_back('{OP_NONE, 32'hFFFF_FFFF, 1'b1, 32'd0});
    tbl.push_back('{OP_INSERT, 32'h0, 1'b1, 32'd0});
    tbl.push_back('{OP_REACCESS, 32'h0, 1'b1, 32'd1});
    tbl.push_back('{OP_REACCESS, 32'hFFFF_FFFF, 1'b0, 32'd0});
    tbl.push_back('{OP_DECR, 32'h5555_AAAA, 1'b0, 32'd0});
    foreach (tbl[k]) send_item(tbl[k].op, tbl[k].old_time, tbl[k].check_dist, tbl[k].distance);

    // Limit of one and limit zero: every increment ages, timestamps advance
    write_limit(32'd1);
    for (int k = 0; k < 8; k++) send_item(k[0] ? OP_REACCESS : OP_INSERT, 32'(k), 1'b0, '0);
    write_limit(32'd0);
    for (int k = 0; k < 8; k++) send_item(k[0] ? OP_DECR : OP_REACCESS, 32'(k + 2), 1'b0, '0);

    // Random phases over several limits, with a full drain between them
    lims = '{32'd2, 32'd3, 32'hFFFF_FFFF, 32'd1, 32'd5};
    for (int p = 0; p < 5; p++) begin
      write_limit(lims[p]);
      for (int n = 0; n < NumRandom / 5; n++) begin
        if (n == 100) drain(0);
        send_item(pick_op(), pick_time(), 1'b0, '0);
      end
    end

    drain(2 * NB + 10);
    if (errors == 0) begin
      $display("** stack_distance_bucket_tracker_unit: PASSED **");
    end else begin
      $display("** stack_distance_bucket_tracker_unit: FAILED **");
    end
    $finish;
  end
endmodule
